[sv/sapq_pkg.sv]
package sapq_pkg;

  localparam int unsigned DEPTH       = 16;
  localparam int unsigned VALUE_WIDTH = 16;
  localparam int unsigned CNT_W       = $clog2(DEPTH + 1);
  localparam int unsigned STATUS_W    = 2;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED = 2'd0,
    ST_FULL     = 2'd1,
    ST_REMOVED  = 2'd2,
    ST_EMPTY    = 2'd3
  } status_e;

  // controller to datapath
  typedef struct packed {
    logic    load;
    logic    push;
    logic    pop;
    status_e status;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic empty;
    logic full;
  } dp_stat_t;

endpackage

[sv/sapq_if.sv]
interface sapq_in_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 opcode;
  logic [sapq_pkg::VALUE_WIDTH-1:0]     value;

  modport source (output valid, output opcode, output value, input ready);
  modport sink   (input valid, input opcode, input value, output ready);
endinterface

interface sapq_out_if;
  logic                                 valid;
  logic                                 ready;
  logic [sapq_pkg::STATUS_W-1:0]        status;
  logic [sapq_pkg::VALUE_WIDTH-1:0]     removed_value;
  logic [sapq_pkg::CNT_W-1:0]           fill_count;

  modport source (output valid, output status, output removed_value, output fill_count,
                  input ready);
  modport sink   (input valid, input status, input removed_value, input fill_count,
                  output ready);
endinterface

[sv/sapq_ctrl.sv]
module sapq_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                opcode_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  sapq_pkg::dp_stat_t  stat_i,
  output sapq_pkg::ctrl_cmd_t cmd_o
);

  typedef enum logic {
    S_IDLE,
    S_HOLD
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;

  // result register frees up in the same cycle it is taken
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o.load   = accept;
    cmd_o.push   = 1'b0;
    cmd_o.pop    = 1'b0;
    cmd_o.status = sapq_pkg::ST_INSERTED;
    if (opcode_i == sapq_pkg::OP_INSERT) begin
      if (stat_i.full) begin
        cmd_o.status = sapq_pkg::ST_FULL;
      end else begin
        cmd_o.push   = accept;
        cmd_o.status = sapq_pkg::ST_INSERTED;
      end
    end else begin
      if (stat_i.empty) begin
        cmd_o.status = sapq_pkg::ST_EMPTY;
      end else begin
        cmd_o.pop    = accept;
        cmd_o.status = sapq_pkg::ST_REMOVED;
      end
    end
  end

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d     = S_HOLD;
          out_valid_d = 1'b1;
        end
      end
      S_HOLD: begin
        if (accept) begin
          state_d     = S_HOLD;
          out_valid_d = 1'b1;
        end else if (out_ready_i) begin
          state_d     = S_IDLE;
          out_valid_d = 1'b0;
        end
      end
      default: begin
        state_d     = S_IDLE;
        out_valid_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

[sv/sapq_dp.sv]
module sapq_dp (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  sapq_pkg::ctrl_cmd_t                  cmd_i,
  input  logic [sapq_pkg::VALUE_WIDTH-1:0]     value_i,
  output sapq_pkg::dp_stat_t                   stat_o,
  output logic [sapq_pkg::STATUS_W-1:0]        status_o,
  output logic [sapq_pkg::VALUE_WIDTH-1:0]     removed_value_o,
  output logic [sapq_pkg::CNT_W-1:0]           fill_count_o
);

  localparam int unsigned VW = sapq_pkg::VALUE_WIDTH;
  localparam int unsigned CW = sapq_pkg::CNT_W;
  localparam int unsigned D  = sapq_pkg::DEPTH;

  logic [VW-1:0]     entries_q [D];
  logic [VW-1:0]     entries_d [D];
  logic [CW-1:0]     count_q, count_d;
  logic [D-1:0]      lt;
  logic [D-1:0]      prev_lt;
  logic [VW-1:0]     prev_val [D];

  sapq_pkg::status_e status_q;
  logic [VW-1:0]     removed_q;
  logic [CW-1:0]     fill_q;

  assign stat_o.empty = (count_q == '0);
  assign stat_o.full  = (count_q == CW'(D));

  // per-cell compare: valid cells holding a smaller value move one place down
  always_comb begin
    prev_lt[0]  = 1'b0;
    prev_val[0] = value_i;
    for (int i = 0; i < D; i++) begin
      lt[i] = (CW'(i) < count_q) && (entries_q[i] < value_i);
    end
    for (int i = 1; i < D; i++) begin
      prev_lt[i]  = lt[i-1];
      prev_val[i] = entries_q[i-1];
    end
  end

  always_comb begin
    for (int i = 0; i < D; i++) begin
      entries_d[i] = entries_q[i];
      if (cmd_i.push && (lt[i] || (CW'(i) == count_q))) begin
        entries_d[i] = prev_lt[i] ? prev_val[i] : value_i;
      end else if (cmd_i.pop && (i < D - 1)) begin
        entries_d[i] = entries_q[(i + 1) % D];
      end
    end
  end

  always_comb begin
    count_d = count_q;
    if (cmd_i.push) begin
      count_d = count_q + CW'(1);
    end else if (cmd_i.pop) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < D; i++) begin
      entries_q[i] <= entries_d[i];
    end
    if (cmd_i.load) begin
      status_q  <= cmd_i.status;
      removed_q <= cmd_i.pop ? entries_q[0] : '0;
      fill_q    <= count_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  assign status_o        = status_q;
  assign removed_value_o = removed_q;
  assign fill_count_o    = fill_q;

endmodule

[sv/sorted_array_priority_queue_core.sv]
// the result beat is valid in the cycle after the input beat is accepted
// throughput: one item per cycle while result beats are taken; every stored cell compares and shifts in parallel
// a new input beat is taken in the cycle the waiting result beat is taken
// reset: stored item count and output valid cleared; stored values and result fields are left as they are
module sorted_array_priority_queue_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  sapq_in_if.sink    in_if,
  sapq_out_if.source out_if
);

  sapq_pkg::ctrl_cmd_t cmd;
  sapq_pkg::dp_stat_t  stat;

  sapq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if.valid),
    .in_ready_o  (in_if.ready),
    .opcode_i    (in_if.opcode),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  sapq_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .value_i         (in_if.value),
    .stat_o          (stat),
    .status_o        (out_if.status),
    .removed_value_o (out_if.removed_value),
    .fill_count_o    (out_if.fill_count)
  );

  a_accept_gives_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_if.valid && in_if.ready) |=> out_if.valid)
    else $error("accepted item produced no result beat");

  a_removed_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_if.valid && (out_if.status != sapq_pkg::ST_REMOVED)) |-> (out_if.removed_value == '0))
    else $error("removed value nonzero without a removal");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid |-> (out_if.fill_count <= sapq_pkg::CNT_W'(sapq_pkg::DEPTH)))
    else $error("fill count beyond depth");

  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_if.valid && (out_if.status == sapq_pkg::ST_FULL))
      |-> (out_if.fill_count == sapq_pkg::CNT_W'(sapq_pkg::DEPTH)))
    else $error("full status with queue not full");

endmodule
